FILE: design/assert_macros.svh
// assertion helpers for the speed regulator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define PIDSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, but also checked while reset is held
`define PIDSR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/pidsr_pkg.sv
`default_nettype none

package pidsr_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned LIM_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FRAC_W    = 16;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic        [GAIN_W-1:0] gain_t;
  typedef logic        [LIM_W-1:0]  lim_t;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_OUTPUT_CEIL  = 3'd3,
    REG_OUTPUT_FLOOR = 3'd4,
    REG_SUM_LIMIT    = 3'd5,
    REG_ERROR_BAND   = 3'd6,
    REG_OUTPUT_BAND  = 3'd7
  } cfg_reg_t;

  localparam gain_t RST_GAIN_P       = 16'd2621;
  localparam gain_t RST_GAIN_I       = 16'd1311;
  localparam gain_t RST_GAIN_D       = 16'd1311;
  localparam lim_t  RST_OUTPUT_CEIL  = 31'd58982;
  localparam q16_t  RST_OUTPUT_FLOOR = 32'sd0;
  localparam lim_t  RST_SUM_LIMIT    = 31'd3932160;
  localparam lim_t  RST_ERROR_BAND   = 31'd655360;
  localparam lim_t  RST_OUTPUT_BAND  = 31'd0;

  // saturate a 33-bit signed value into 32 bits
  function automatic q16_t sat33(input logic signed [DATA_W:0] v);
    q16_t r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? q16_t'({1'b1, {(DATA_W-1){1'b0}}}) : q16_t'({1'b0, {(DATA_W-1){1'b1}}});
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // magnitude of a 32-bit signed value compared against an unsigned band
  function automatic logic within_band(input q16_t v, input lim_t band);
    logic signed [DATA_W:0] ext;
    logic signed [DATA_W:0] m;
    ext = {v[DATA_W-1], v};
    m   = ext[DATA_W] ? -ext : ext;
    return m[DATA_W:0] <= {2'b00, band};
  endfunction

endpackage

`default_nettype wire

FILE: design/pid_speed_regulator_top.sv
// an input beat passes through five register ranks: A, B, C, D and the result register
// throughput: one beat per cycle unless stalled; error-sum update closes in a single stage
// backpressure freezes every rank at once; in_ready is out_ready or an empty result rank
// reset: synchronous, active low; clears all valids, the error history and the error sum,
// and loads every configuration register with its documented default
`default_nettype none

`include "assert_macros.svh"

module pid_speed_regulator_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input channel
  input  wire logic                                  in_valid,
  output      logic                                  in_ready,
  input  wire logic signed [pidsr_pkg::DATA_W-1:0]   in_measured,
  input  wire logic signed [pidsr_pkg::DATA_W-1:0]   in_setpoint,
  input  wire logic                                  in_regulate,
  // result channel
  output      logic                                  out_valid,
  input  wire logic                                  out_ready,
  output      logic signed [pidsr_pkg::DATA_W-1:0]   out_drive,
  output      logic                                  out_settled,
  // configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic        [pidsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [pidsr_pkg::DATA_W-1:0]   cfg_data
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  pidsr_pkg::gain_t gain_p_r, gain_i_r, gain_d_r;
  pidsr_pkg::lim_t  out_ceil_r, sum_limit_r, err_band_r, out_band_r;
  pidsr_pkg::q16_t  out_floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= pidsr_pkg::RST_GAIN_P;
      gain_i_r    <= pidsr_pkg::RST_GAIN_I;
      gain_d_r    <= pidsr_pkg::RST_GAIN_D;
      out_ceil_r  <= pidsr_pkg::RST_OUTPUT_CEIL;
      out_floor_r <= pidsr_pkg::RST_OUTPUT_FLOOR;
      sum_limit_r <= pidsr_pkg::RST_SUM_LIMIT;
      err_band_r  <= pidsr_pkg::RST_ERROR_BAND;
      out_band_r  <= pidsr_pkg::RST_OUTPUT_BAND;
    end else if (cfg_we) begin
      case (pidsr_pkg::cfg_reg_t'(cfg_index))
        pidsr_pkg::REG_GAIN_P:       gain_p_r    <= cfg_data[pidsr_pkg::GAIN_W-1:0];
        pidsr_pkg::REG_GAIN_I:       gain_i_r    <= cfg_data[pidsr_pkg::GAIN_W-1:0];
        pidsr_pkg::REG_GAIN_D:       gain_d_r    <= cfg_data[pidsr_pkg::GAIN_W-1:0];
        pidsr_pkg::REG_OUTPUT_CEIL:  out_ceil_r  <= cfg_data[pidsr_pkg::LIM_W-1:0];
        pidsr_pkg::REG_OUTPUT_FLOOR: out_floor_r <= cfg_data;
        pidsr_pkg::REG_SUM_LIMIT:    sum_limit_r <= cfg_data[pidsr_pkg::LIM_W-1:0];
        pidsr_pkg::REG_ERROR_BAND:   err_band_r  <= cfg_data[pidsr_pkg::LIM_W-1:0];
        pidsr_pkg::REG_OUTPUT_BAND:  out_band_r  <= cfg_data[pidsr_pkg::LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: every rank moves together when the result register
  // is empty or its beat is being taken
  // ---------------------------------------------------------------------------
  logic adv;
  logic a_valid_r, b_valid_r, c_valid_r, d_valid_r, out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= in_valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      out_valid_r <= d_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // rank A: input register
  // ---------------------------------------------------------------------------
  pidsr_pkg::q16_t a_meas_r, a_setp_r;
  logic            a_on_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_meas_r <= in_measured;
      a_setp_r <= in_setpoint;
      a_on_r   <= in_regulate;
    end
  end

  // ---------------------------------------------------------------------------
  // rank B: saturated error
  // ---------------------------------------------------------------------------
  logic signed [pidsr_pkg::DATA_W:0] err_wide;
  pidsr_pkg::q16_t b_err_nxt, b_err_r;
  logic            b_on_r;

  assign err_wide  = {a_setp_r[pidsr_pkg::DATA_W-1], a_setp_r}
                   - {a_meas_r[pidsr_pkg::DATA_W-1], a_meas_r};
  assign b_err_nxt = pidsr_pkg::sat33(err_wide);

  always_ff @(posedge clk) begin
    if (adv) begin
      b_err_r <= b_err_nxt;
      b_on_r  <= a_on_r;
    end
  end

  // ---------------------------------------------------------------------------
  // rank C: error sum with clamp, derivative difference, error band check
  // the history registers advance only with a real beat
  // ---------------------------------------------------------------------------
  pidsr_pkg::q16_t last_error_r, error_sum_r;
  logic signed [pidsr_pkg::DATA_W:0] sum_wide, sum_sat, lim_pos, lim_neg, sum_clamped;
  logic signed [pidsr_pkg::DATA_W:0] diff_nxt;
  pidsr_pkg::q16_t                   sum_sat32;
  pidsr_pkg::q16_t                   sum_nxt;
  logic                              upd;

  assign upd       = adv && b_valid_r;
  assign sum_wide  = {error_sum_r[pidsr_pkg::DATA_W-1], error_sum_r}
                   + {b_err_r[pidsr_pkg::DATA_W-1], b_err_r};
  assign sum_sat32 = pidsr_pkg::sat33(sum_wide);
  assign sum_sat   = {sum_sat32[pidsr_pkg::DATA_W-1], sum_sat32};
  assign lim_pos   = {2'b00, sum_limit_r};
  assign lim_neg   = -lim_pos;

  always_comb begin
    sum_clamped = sum_sat;
    if (sum_sat > lim_pos) begin
      sum_clamped = lim_pos;
    end
    if (sum_sat < lim_neg) begin
      sum_clamped = lim_neg;
    end
  end

  // clamped value is within +-(2^31-1), so the low 32 bits hold it exactly
  assign sum_nxt  = sum_clamped[pidsr_pkg::DATA_W-1:0];
  assign diff_nxt = {b_err_r[pidsr_pkg::DATA_W-1], b_err_r}
                  - {last_error_r[pidsr_pkg::DATA_W-1], last_error_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      error_sum_r  <= '0;
    end else if (upd) begin
      last_error_r <= b_err_r;
      error_sum_r  <= sum_nxt;
    end
  end

  pidsr_pkg::q16_t                   c_err_r, c_sum_r;
  logic signed [pidsr_pkg::DATA_W:0] c_diff_r;
  logic                              c_on_r, c_err_ok_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_err_r    <= b_err_r;
      c_sum_r    <= sum_nxt;
      c_diff_r   <= diff_nxt;
      c_on_r     <= b_on_r;
      c_err_ok_r <= pidsr_pkg::within_band(b_err_r, err_band_r);
    end
  end

  // ---------------------------------------------------------------------------
  // rank D: three gain products in parallel (unsigned Q0.16 times signed)
  // ---------------------------------------------------------------------------
  localparam int unsigned PW = pidsr_pkg::DATA_W + pidsr_pkg::GAIN_W + 1;

  logic signed [PW-1:0] pp_nxt, pi_nxt;
  logic signed [PW:0]   pd_nxt;
  logic signed [PW-1:0] d_pp_r, d_pi_r;
  logic signed [PW:0]   d_pd_r;
  logic                 d_on_r, d_err_ok_r;

  assign pp_nxt = $signed({1'b0, gain_p_r}) * c_err_r;
  assign pi_nxt = $signed({1'b0, gain_i_r}) * c_sum_r;
  assign pd_nxt = $signed({1'b0, gain_d_r}) * c_diff_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_pp_r     <= pp_nxt;
      d_pi_r     <= pi_nxt;
      d_pd_r     <= pd_nxt;
      d_on_r     <= c_on_r;
      d_err_ok_r <= c_err_ok_r;
    end
  end

  // ---------------------------------------------------------------------------
  // rank E: accumulate, floor shift, clip to ceiling, zero below floor
  // ---------------------------------------------------------------------------
  localparam int unsigned AW = PW + 3;
  localparam int unsigned SW = AW - pidsr_pkg::FRAC_W;

  logic signed [AW-1:0] acc;
  logic signed [SW-1:0] shifted, clipped, ceil_ext, floor_ext;
  pidsr_pkg::q16_t      drive_nxt;
  logic                 settled_nxt;

  assign acc       = d_pp_r + d_pi_r + d_pd_r;
  // dropping the fraction bits of a two's complement value rounds toward minus infinity
  assign shifted   = acc[AW-1:pidsr_pkg::FRAC_W];
  assign ceil_ext  = $signed({{(SW-pidsr_pkg::LIM_W){1'b0}}, out_ceil_r});
  assign floor_ext = $signed({{(SW-pidsr_pkg::DATA_W){out_floor_r[pidsr_pkg::DATA_W-1]}},
                              out_floor_r});

  always_comb begin
    clipped = (shifted > ceil_ext) ? ceil_ext : shifted;
    if (clipped < floor_ext) begin
      clipped = '0;
    end
    // anything left is zero or lies between the floor and the ceiling, both 32-bit values
    drive_nxt   = d_on_r ? clipped[pidsr_pkg::DATA_W-1:0] : '0;
    settled_nxt = d_on_r && d_err_ok_r
                  && pidsr_pkg::within_band(clipped[pidsr_pkg::DATA_W-1:0], out_band_r);
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  pidsr_pkg::q16_t out_drive_r;
  logic            out_settled_r, out_on_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_drive_r   <= drive_nxt;
      out_settled_r <= settled_nxt;
      out_on_r      <= d_on_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_settled = out_settled_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `PIDSR_ASSERT(a_off_forces_zero,
    (out_valid_r && !out_on_r) |-> (out_drive_r == '0 && !out_settled_r),
    "drive or settled nonzero with regulation off")

  `PIDSR_ASSERT(a_drive_below_ceiling,
    out_valid_r |-> (out_drive_r <= $signed({1'b0, out_ceil_r})),
    "drive above output ceiling")

  `PIDSR_ASSERT(a_settled_in_band,
    (out_valid_r && out_settled_r) |->
      pidsr_pkg::within_band(out_drive_r, out_band_r),
    "settled flagged with drive outside its band")

  `PIDSR_ASSERT(a_history_holds,
    !upd |=> ($stable(error_sum_r) && $stable(last_error_r)),
    "error history changed without a beat in the sum stage")

endmodule

`default_nettype wire
